[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[sv/svi_pkg.sv]
// ----------------------------------------------------------------------------
// svi_pkg
// Shared constants, codes and types of the snapshot image validator.
// ----------------------------------------------------------------------------
package svi_pkg;

	localparam logic [31:0] SVI_RESET_MAGIC   = 32'h4453_4245;
	localparam logic [15:0] SVI_RESET_VERSION = 16'd9;
	localparam logic [31:0] SVI_RESET_POLY    = 32'hEDB8_8420;
	localparam logic [31:0] SVI_CRC_ONES      = 32'hFFFF_FFFF;
	localparam logic [4:0]  SVI_HDR_BYTES     = 5'd20;
	localparam int          SVI_QUEUE_DEPTH   = 2;
	localparam int          SVI_CFG_IDX_W     = 2;

	typedef enum logic [SVI_CFG_IDX_W-1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_VERSION = 2'd1,
		CFG_POLY    = 2'd2
	} svi_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TRUNC   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_CRC     = 3'd4
	} svi_status_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        crc_init;
		logic        do_crc;
		logic        emit;
		logic        check_crc;
		svi_status_t status;
		logic        hdr_done;
		logic        hdr_ok;
		logic [31:0] seq;
		logic [31:0] length;
		logic [31:0] stored_crc;
	} svi_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} svi_qstat_t;

endpackage

[sv/svi_if.sv]
// ----------------------------------------------------------------------------
// svi_if
// Valid/ready channels for image bytes and verdicts.
// ----------------------------------------------------------------------------
interface svi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_available;

	modport source (output valid, data_byte, first_byte, last_available, input ready);
	modport sink   (input valid, data_byte, first_byte, last_available, output ready);
endinterface

interface svi_out_if;
	logic        valid;
	logic        ready;
	logic        image_valid;
	logic [2:0]  status;
	logic [31:0] sequence_res;
	logic [31:0] payload_length;
	logic [31:0] computed_crc;

	modport source (output valid, image_valid, status, sequence_res, payload_length,
		computed_crc, input ready);
	modport sink   (input valid, image_valid, status, sequence_res, payload_length,
		computed_crc, output ready);
endinterface

[sv/snapshot_image_validator.sv]
// ----------------------------------------------------------------------------
// snapshot_image_validator
// Header check and payload 32-bit CRC verdict for snapshot images.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the queue is not full. The header
// parser classifies each byte in the cycle it is taken; payload bytes and
// verdict requests pass through a QUEUE_DEPTH-entry queue to the CRC engine,
// which retires one entry per cycle, unless a verdict waits unaccepted, with a
// single byte-wide, eight-step CRC update. A verdict passes from the queue
// through the output register to verdict_out. While a verdict waits unaccepted
// in the output register the engine retires nothing, so the queue takes up to
// QUEUE_DEPTH further payload or verdict entries before byte_in drops ready;
// other header bytes take no entry. There is no clearing pass after reset.
`include "assert_macros.svh"

module snapshot_image_validator #(
	parameter int QUEUE_DEPTH = svi_pkg::SVI_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	svi_in_if.sink                            byte_in,
	svi_out_if.source                         verdict_out,
	input  logic                              cfg_we,
	input  logic [svi_pkg::SVI_CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                       cfg_wdata
);
	import svi_pkg::*;

	logic [31:0] magic_q, poly_q;
	logic [15:0] version_q;
	logic        push, pop;
	svi_op_t     push_op, pop_op;
	svi_qstat_t  qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= SVI_RESET_MAGIC;
			version_q <= SVI_RESET_VERSION;
			poly_q    <= SVI_RESET_POLY;
		end else if (cfg_we) begin
			case (svi_cfg_idx_t'(cfg_idx))
				CFG_MAGIC:   magic_q   <= cfg_wdata;
				CFG_VERSION: version_q <= cfg_wdata[15:0];
				CFG_POLY:    poly_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	svi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.qstat       (qstat),
		.exp_magic   (magic_q),
		.exp_version (version_q),
		.push        (push),
		.push_op     (push_op)
	);

	svi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.qstat   (qstat)
	);

	svi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (pop_op),
		.qstat       (qstat),
		.poly        (poly_q),
		.pop         (pop),
		.verdict_out (verdict_out)
	);

	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && qstat.full, "push into full queue")
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && qstat.empty, "pop from empty queue")
	`ASSERT_CLK(a_verdict_flag, clk, arst_n, verdict_out.valid |-> (verdict_out.image_valid == (verdict_out.status == ST_OK)), "image_valid disagrees with status")

endmodule

[sv/svi_front.sv]
// ----------------------------------------------------------------------------
// svi_front
// Header parser: takes bytes, tracks position, checks the header and
// hands payload bytes and verdict requests to the queue.
// ----------------------------------------------------------------------------
module svi_front (
	input  logic                clk,
	input  logic                arst_n,
	svi_in_if.sink              byte_in,
	input  svi_pkg::svi_qstat_t qstat,
	input  logic [31:0]         exp_magic,
	input  logic [15:0]         exp_version,
	output logic                push,
	output svi_pkg::svi_op_t    push_op
);
	import svi_pkg::*;

	logic [4:0]  hdr_cnt_q;
	logic        done_q;
	logic        fresh_q;
	logic [31:0] remain_q;
	logic [31:0] magic_q, seq_q, crc_q, len_q;
	logic [15:0] ver_q;

	logic [31:0] magic_nx, seq_nx, crc_nx, len_nx;
	logic [15:0] ver_nx;
	logic [4:0]  off;
	logic        active, in_hdr, accept, fresh;
	svi_op_t     op;

	assign byte_in.ready = !qstat.full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign off           = byte_in.first_byte ? '0 : hdr_cnt_q;
	assign active        = byte_in.first_byte || !done_q;
	assign in_hdr        = off != SVI_HDR_BYTES;
	assign fresh         = byte_in.first_byte || fresh_q;

	always_comb begin
		magic_nx = magic_q;
		ver_nx   = ver_q;
		seq_nx   = seq_q;
		crc_nx   = crc_q;
		len_nx   = len_q;
		case (off) inside
			[5'd0:5'd3]:   magic_nx[off[1:0]*8 +: 8] = byte_in.data_byte;
			[5'd4:5'd5]:   ver_nx[off[0]*8 +: 8]     = byte_in.data_byte;
			[5'd8:5'd11]:  seq_nx[off[1:0]*8 +: 8]   = byte_in.data_byte;
			[5'd12:5'd15]: crc_nx[off[1:0]*8 +: 8]   = byte_in.data_byte;
			[5'd16:5'd19]: len_nx[off[1:0]*8 +: 8]   = byte_in.data_byte;
			default: ;
		endcase
	end

	always_comb begin
		op            = '0;
		op.data       = byte_in.data_byte;
		op.crc_init   = fresh;
		op.status     = ST_OK;
		op.seq        = seq_nx;
		op.length     = len_nx;
		op.stored_crc = crc_nx;
		if (in_hdr) begin
			if (off == SVI_HDR_BYTES - 5'd1) begin
				op.hdr_done = 1'b1;
				if (magic_nx != exp_magic) begin
					op.emit   = 1'b1;
					op.status = ST_MAGIC;
				end else if (ver_nx != exp_version) begin
					op.emit   = 1'b1;
					op.status = ST_VERSION;
				end else if (len_nx == '0) begin
					op.emit      = 1'b1;
					op.check_crc = 1'b1;
					op.hdr_ok    = 1'b1;
				end else if (byte_in.last_available) begin
					op.emit   = 1'b1;
					op.status = ST_TRUNC;
					op.hdr_ok = 1'b1;
				end
			end else if (byte_in.last_available) begin
				op.emit   = 1'b1;
				op.status = ST_TRUNC;
			end
		end else begin
			op.do_crc   = 1'b1;
			op.hdr_done = 1'b1;
			op.hdr_ok   = 1'b1;
			if (remain_q == 32'd1) begin
				op.emit      = 1'b1;
				op.check_crc = 1'b1;
			end else if (byte_in.last_available) begin
				op.emit   = 1'b1;
				op.status = ST_TRUNC;
			end
		end
	end

	assign push    = accept && active && (op.emit || op.do_crc);
	assign push_op = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			done_q    <= 1'b1;
			fresh_q   <= 1'b1;
		end else if (accept && active) begin
			hdr_cnt_q <= in_hdr ? 5'(off + 5'd1) : off;
			done_q    <= op.emit;
			fresh_q   <= push ? 1'b0 : fresh;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			magic_q  <= magic_nx;
			ver_q    <= ver_nx;
			seq_q    <= seq_nx;
			crc_q    <= crc_nx;
			len_q    <= len_nx;
			remain_q <= in_hdr ? len_nx : 32'(remain_q - 32'd1);
		end
	end

endmodule

[sv/svi_queue.sv]
// ----------------------------------------------------------------------------
// svi_queue
// Short queue of classified operations between parser and CRC engine.
// ----------------------------------------------------------------------------
module svi_queue #(
	parameter int DEPTH = svi_pkg::SVI_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  svi_pkg::svi_op_t    push_op,
	input  logic                pop,
	output svi_pkg::svi_op_t    pop_op,
	output svi_pkg::svi_qstat_t qstat
);
	import svi_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	svi_op_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign pop_op      = mem_q[rd_ptr_q];
	assign qstat.full  = cnt_q == CNT_W'(DEPTH);
	assign qstat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/svi_back.sv]
// ----------------------------------------------------------------------------
// svi_back
// CRC engine: runs the byte-wide 32-bit CRC update and registers verdicts.
// ----------------------------------------------------------------------------
module svi_back (
	input  logic                clk,
	input  logic                arst_n,
	input  svi_pkg::svi_op_t    op,
	input  svi_pkg::svi_qstat_t qstat,
	input  logic [31:0]         poly,
	output logic                pop,
	svi_out_if.source           verdict_out
);
	import svi_pkg::*;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
		input logic [7:0] b, input logic [31:0] p);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (p & {32{c[0]}});
		end
		return c;
	endfunction

	logic [31:0] crc_q;
	logic        vld_q;
	logic [31:0] crc_base, crc_nx, fin;
	svi_status_t st;

	assign pop      = !qstat.empty && (!vld_q || verdict_out.ready);
	assign crc_base = op.crc_init ? SVI_CRC_ONES : crc_q;
	assign crc_nx   = op.do_crc ? crc_byte(crc_base, op.data, poly) : crc_base;
	assign fin      = crc_nx ^ SVI_CRC_ONES;
	assign st       = op.check_crc ? ((fin == op.stored_crc) ? ST_OK : ST_CRC) : op.status;

	assign verdict_out.valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= SVI_CRC_ONES;
			vld_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= crc_nx;
			end
			if (pop && op.emit) begin
				vld_q <= 1'b1;
			end else if (verdict_out.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.emit) begin
			verdict_out.image_valid    <= st == ST_OK;
			verdict_out.status         <= 3'(st);
			verdict_out.sequence_res   <= op.hdr_done ? op.seq : '0;
			verdict_out.payload_length <= op.hdr_done ? op.length : '0;
			verdict_out.computed_crc   <= op.hdr_ok ? fin : '0;
		end
	end

endmodule

[tb/snapshot_image_validator_test.sv]
// ----------------------------------------------------------------------------
// snapshot_image_validator_test
// Self-checking bench for the snapshot image header and 32-bit CRC verdicts.
// ----------------------------------------------------------------------------
// Images are built byte by byte: well-formed ones with a CRC worked out under
// the current polynomial, and broken ones (bad magic, bad version, wrong CRC,
// truncated, abandoned) plus stray bytes. A predictor in the bench follows
// every accepted byte and queues the verdict it expects. Each verdict taken
// from the block is compared field by field with the oldest one queued.
// Both channels idle at random, the verdict side holds off once for a long
// stretch, and the register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module snapshot_image_validator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import svi_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 250;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} byte_beat_t;

	typedef struct packed {
		logic        image_valid;
		svi_status_t status;
		logic [31:0] seq;
		logic [31:0] len;
		logic [31:0] crc;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	svi_cfg_idx_t cfg_idx;
	logic [31:0]  cfg_wdata;

	svi_in_if  byte_if ();
	svi_out_if verdict_if ();

	snapshot_image_validator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_if),
		.verdict_out (verdict_if),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

	always #6 clk = ~clk;

	// register copies
	logic [31:0] cfg_magic;
	logic [15:0] cfg_version;
	logic [31:0] cfg_poly;

	// image parse state
	logic [32:0] img_offset;
	logic [31:0] hdr_magic;
	logic [15:0] hdr_version;
	logic [31:0] hdr_seq;
	logic [31:0] hdr_stored_crc;
	logic [31:0] hdr_length;
	logic [31:0] crc_acc;
	bit          verdict_done;

	byte_beat_t image_bytes [$];
	verdict_t   verdicts_due [$];
	byte_beat_t next_beat;
	verdict_t   predicted;
	verdict_t   want;

	int  bytes_pushed;
	int  bytes_taken;
	int  phase_bytes;
	int  mismatches;
	int  cycles;
	int  status_count [0:4];
	int  settings_used;
	bit  byte_sent;
	bit  verdict_taken;
	int  gap_left;
	int  send_mode_left;
	bit  send_calm;
	int  ready_wait;
	int  recv_mode_left;
	bit  recv_calm;
	int  hold_left;

	function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b,
		input logic [31:0] poly);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = (c >> 1) ^ (c[0] ? poly : 32'd0);
		return c;
	endfunction

	function automatic verdict_t close_image(input svi_status_t st, input bit hdr_done,
		input bit hdr_ok);
		verdict_t v;
		verdict_done = 1'b1;
		v.image_valid = (st == ST_OK);
		v.status = st;
		v.seq = hdr_done ? hdr_seq : 32'd0;
		v.len = hdr_done ? hdr_length : 32'd0;
		v.crc = (hdr_done && hdr_ok) ? ~crc_acc : 32'd0;
		return v;
	endfunction

	function automatic bit take_image_byte(input logic [7:0] b, input bit first, input bit last,
		output verdict_t v);
		logic [4:0] off;
		v = '0;
		if (first) begin
			img_offset = '0;
			hdr_magic = '0;
			hdr_version = '0;
			hdr_seq = '0;
			hdr_stored_crc = '0;
			hdr_length = '0;
			crc_acc = SVI_CRC_ONES;
			verdict_done = 1'b0;
		end else if (verdict_done) begin
			return 1'b0;
		end
		if (img_offset < SVI_HDR_BYTES) begin
			off = img_offset[4:0];
			if (off < 4)
				hdr_magic[8*off +: 8] = b;
			else if (off < 6)
				hdr_version[8*(off-4) +: 8] = b;
			else if (off >= 8 && off < 12)
				hdr_seq[8*(off-8) +: 8] = b;
			else if (off >= 12 && off < 16)
				hdr_stored_crc[8*(off-12) +: 8] = b;
			else if (off >= 16)
				hdr_length[8*(off-16) +: 8] = b;
			img_offset++;
			if (img_offset == SVI_HDR_BYTES) begin
				if (hdr_magic != cfg_magic) begin
					v = close_image(ST_MAGIC, 1'b1, 1'b0);
					return 1'b1;
				end
				if (hdr_version != cfg_version) begin
					v = close_image(ST_VERSION, 1'b1, 1'b0);
					return 1'b1;
				end
				if (hdr_length == 32'd0) begin
					v = close_image((~crc_acc == hdr_stored_crc) ? ST_OK : ST_CRC, 1'b1, 1'b1);
					return 1'b1;
				end
				if (last) begin
					v = close_image(ST_TRUNC, 1'b1, 1'b1);
					return 1'b1;
				end
			end else if (last) begin
				v = close_image(ST_TRUNC, 1'b0, 1'b0);
				return 1'b1;
			end
			return 1'b0;
		end
		crc_acc = crc_update(crc_acc, b, cfg_poly);
		img_offset++;
		if (img_offset == SVI_HDR_BYTES + {1'b0, hdr_length}) begin
			v = close_image((~crc_acc == hdr_stored_crc) ? ST_OK : ST_CRC, 1'b1, 1'b1);
			return 1'b1;
		end
		if (last) begin
			v = close_image(ST_TRUNC, 1'b1, 1'b1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int idle_draw(inout int mode_left, inout bit calm);
		if (mode_left == 0) begin
			calm = ($urandom_range(0, 2) == 0);
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic queue_beat(input logic [7:0] data, input bit first, input bit last);
		byte_beat_t beat;
		beat.data = data;
		beat.first = first;
		beat.last = last;
		image_bytes.push_back(beat);
		bytes_pushed++;
		phase_bytes++;
	endtask

	// cut < 0 sends the whole image; otherwise bytes 0..cut only, clipped to the image
	task automatic push_image(input logic [31:0] magic, input logic [15:0] ver,
		input logic [31:0] seq, input logic [31:0] len, input bit good_crc, input int cut,
		input bit end_mark);
		logic [7:0]   pay_q [$];
		logic [7:0]   b;
		logic [31:0]  crc;
		logic [31:0]  stored;
		logic [159:0] hdr;
		longint       total;
		longint       upto;
		int           n;
		total = 64'd20 + len;
		upto = (cut >= 0 && cut < total) ? cut + 1 : total;
		n = int'(upto);
		crc = SVI_CRC_ONES;
		for (int j = 20; j < n; j++) begin
			b = 8'($urandom);
			pay_q.push_back(b);
			crc = crc_update(crc, b, cfg_poly);
		end
		crc = ~crc;
		stored = good_crc ? crc : (crc ^ ($urandom | 32'd1));
		hdr = {len, stored, seq, 16'($urandom), ver, magic};
		for (int i = 0; i < n; i++)
			queue_beat((i < 20) ? hdr[8*i +: 8] : pay_q[i-20], i == 0, end_mark && i == n - 1);
	endtask

	task automatic push_noise(input int n, input bit allow_first);
		for (int i = 0; i < n; i++)
			queue_beat(8'($urandom), allow_first && $urandom_range(0, 5) == 0,
				1'($urandom_range(0, 1)));
	endtask

	task automatic random_image();
		int          kind;
		logic [31:0] len;
		longint      span;
		int          cut;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 24);
		if (kind < 55) begin
			push_image(cfg_magic, cfg_version, $urandom, len, 1'b1, -1,
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				push_noise($urandom_range(1, 3), 1'b0);
		end else if (kind < 65) begin
			push_image(cfg_magic, cfg_version, $urandom, len, 1'b0, -1,
				1'($urandom_range(0, 1)));
		end else if (kind < 72) begin
			push_image(cfg_magic ^ ($urandom | 32'd1), 16'($urandom), $urandom, $urandom, 1'b1,
				19 + $urandom_range(0, 3), 1'($urandom_range(0, 1)));
		end else if (kind < 78) begin
			push_image(cfg_magic, cfg_version ^ 16'($urandom_range(1, 65535)), $urandom,
				$urandom, 1'b1, 19 + $urandom_range(0, 3), 1'($urandom_range(0, 1)));
		end else if (kind < 95) begin
			if ($urandom_range(0, 1) == 0)
				len = $urandom;
			else
				len = len + 32'd1;
			span = 64'd19 + len;
			if (span > 45)
				span = 45;
			cut = $urandom_range(0, int'(span));
			push_image(cfg_magic, cfg_version, $urandom, len, 1'b1, cut, kind < 90);
		end else begin
			push_noise($urandom_range(1, 8), 1'b1);
		end
	endtask

	task automatic write_reg(input svi_cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_MAGIC: cfg_magic = value;
			CFG_VERSION: cfg_version = value[15:0];
			CFG_POLY: cfg_poly = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_taken != bytes_pushed || verdicts_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
		end else if (!byte_if.valid || byte_sent) begin
			byte_sent = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				byte_if.valid <= 1'b0;
			end else if (image_bytes.size() != 0) begin
				next_beat = image_bytes.pop_front();
				byte_if.data_byte <= next_beat.data;
				byte_if.first_byte <= next_beat.first;
				byte_if.last_available <= next_beat.last;
				byte_if.valid <= 1'b1;
				gap_left = idle_draw(send_mode_left, send_calm);
			end else begin
				byte_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_if.valid && byte_if.ready) begin
			byte_sent = 1'b1;
			bytes_taken++;
			if (take_image_byte(byte_if.data_byte, byte_if.first_byte, byte_if.last_available,
				predicted))
				verdicts_due.push_back(predicted);
		end
	end

	// verdict side ready
	always @(negedge clk) begin
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
		end else begin
			if (verdict_taken) begin
				verdict_taken = 1'b0;
				ready_wait = idle_draw(recv_mode_left, recv_calm);
			end
			if (hold_left > 0) begin
				hold_left--;
				verdict_if.ready <= 1'b0;
			end else if (ready_wait > 0) begin
				ready_wait--;
				verdict_if.ready <= 1'b0;
			end else begin
				verdict_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_if.valid && verdict_if.ready) begin
			verdict_taken = 1'b1;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected verdict status=%0d seq=%h len=%h crc=%h", $time,
					verdict_if.status, verdict_if.sequence_res, verdict_if.payload_length,
					verdict_if.computed_crc);
			end else begin
				want = verdicts_due.pop_front();
				status_count[want.status]++;
				if (verdict_if.image_valid !== want.image_valid ||
					verdict_if.status !== want.status ||
					verdict_if.sequence_res !== want.seq ||
					verdict_if.payload_length !== want.len ||
					verdict_if.computed_crc !== want.crc) begin
					mismatches++;
					$display("%0t: verdict mismatch: expected valid=%0b status=%0d seq=%h len=%h crc=%h",
						$time, want.image_valid, want.status, want.seq, want.len, want.crc);
					$display("%0t:                   actual valid=%0b status=%0d seq=%h len=%h crc=%h",
						$time, verdict_if.image_valid, verdict_if.status, verdict_if.sequence_res,
						verdict_if.payload_length, verdict_if.computed_crc);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d verdicts outstanding", $time, verdicts_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = 8'd0;
		byte_if.first_byte = 1'b0;
		byte_if.last_available = 1'b0;
		verdict_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MAGIC;
		cfg_wdata = 32'd0;
		cfg_magic = SVI_RESET_MAGIC;
		cfg_version = SVI_RESET_VERSION;
		cfg_poly = SVI_RESET_POLY;
		img_offset = '0;
		hdr_magic = '0;
		hdr_version = '0;
		hdr_seq = '0;
		hdr_stored_crc = '0;
		hdr_length = '0;
		crc_acc = SVI_CRC_ONES;
		verdict_done = 1'b1;
		settings_used = 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stray bytes while idle, then the directed images
		push_noise(2, 1'b0);
		push_image(cfg_magic, cfg_version, 32'd0, 32'd0, 1'b1, -1, 1'b1);
		push_image(cfg_magic, cfg_version, 32'hFFFF_FFFF, 32'd0, 1'b0, -1, 1'b0);
		push_image(cfg_magic, cfg_version, $urandom, 32'd4, 1'b1, -1, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd3, 1'b0, -1, 1'b0);
		push_image(cfg_magic ^ 32'd1, cfg_version, $urandom, 32'hFFFF_FFFF, 1'b1, 21, 1'b1);
		push_image(~cfg_magic, ~cfg_version, $urandom, 32'd2, 1'b1, -1, 1'b1);
		push_image(cfg_magic, cfg_version ^ 16'hFFFF, $urandom, 32'd2, 1'b1, -1, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd6, 1'b1, 9, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd6, 1'b1, 0, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd5, 1'b1, 19, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd10, 1'b1, 22, 1'b1);
		push_image(cfg_magic, cfg_version, $urandom, 32'd8, 1'b1, 12, 1'b0);
		push_image(cfg_magic, cfg_version, $urandom, 32'd2, 1'b1, -1, 1'b1);
		push_noise(3, 1'b0);
		push_image(cfg_magic, cfg_version, $urandom, 32'd16, 1'b1, -1, 1'b1);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_reg(CFG_POLY, 32'hEDB8_8320);
				1: begin
					write_reg(CFG_MAGIC, 32'd0);
					write_reg(CFG_VERSION, 32'd0);
				end
				2: begin
					write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
					write_reg(CFG_VERSION, 32'h0000_FFFF);
					write_reg(CFG_POLY, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(CFG_MAGIC, $urandom);
					write_reg(CFG_VERSION, $urandom_range(0, 65535));
					write_reg(CFG_POLY, 32'd0);
				end
				4: write_reg(CFG_POLY, $urandom | 32'h8000_0000);
				default: begin
					write_reg(CFG_MAGIC, SVI_RESET_MAGIC);
					write_reg(CFG_VERSION, {16'd0, SVI_RESET_VERSION});
					write_reg(CFG_POLY, SVI_RESET_POLY);
				end
			endcase
			settings_used++;
			// hold the verdict side off so the block backs up into its input
			if (phase == 1)
				hold_left = 400;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				random_image();
			wait_idle();
		end

		$display("Run covered %0d image bytes under %0d register settings.", bytes_taken,
			settings_used);
		$display("Verdicts: ok %0d, truncated %0d, bad magic %0d, bad version %0d, crc %0d.",
			status_count[0], status_count[1], status_count[2], status_count[3],
			status_count[4]);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
